// ===== hdl/sofp_pkg.sv =====
// shared types and constants of the start/length/checksum frame parser
// no dependencies; used by every module of the block
package sofp_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_CSUM_ERR = 2'd2,
    KIND_LEN_ERR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_TIMEOUT    = 2'd1
  } cfg_idx_e;

  localparam logic [7:0]  START_BYTE_RST = 8'hAA;
  localparam logic [31:0] TIMEOUT_RST    = 32'd100;

  // frame verdict handed from the intake side to the drain side
  typedef struct packed {
    kind_e      kind;
    logic [7:0] frame_len;
    logic [7:0] err_cnt;
  } cmd_t;

  // payload buffer write port
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } wr_t;

endpackage

// ===== hdl/sofp_front.sv =====
// byte intake: framing state machine, timeout, checksum and error count
// depends on sofp_pkg; feeds sofp_cmd_fifo and the payload buffer in sofp_back
module sofp_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  logic [31:0]       rx_tick_i,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              fifo_full_i,
  input  logic              drain_busy_i,
  output logic              push_o,
  output sofp_pkg::cmd_t    cmd_o,
  output sofp_pkg::wr_t     wr_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_PAY,
    PH_SUM
  } phase_e;

  phase_e      phase_q, phase_d, phase_eff;
  logic [7:0]  start_q;
  logic [31:0] timeout_q;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  err_q, err_d;
  logic [31:0] prev_q;
  logic [31:0] gap;
  logic        accept;
  logic        timed_out;

  // hold off payload while the buffer is still being drained,
  // and frame-closing bytes while the verdict queue is full
  assign in_ready_o = !((phase_q == PH_PAY && drain_busy_i) ||
                        ((phase_q == PH_LEN || phase_q == PH_SUM) && fifo_full_i));
  assign accept     = in_valid_i && in_ready_o;
  assign gap        = rx_tick_i - prev_q;
  assign timed_out  = (phase_q != PH_HUNT) && (gap >= timeout_q);
  assign phase_eff  = timed_out ? PH_HUNT : phase_q;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    err_d   = err_q;
    push_o  = 1'b0;
    cmd_o   = '{kind: sofp_pkg::KIND_PAYLOAD, frame_len: len_q, err_cnt: err_q};
    wr_o    = '{en: 1'b0, addr: cnt_q, data: rx_byte_i};
    if (accept) begin
      phase_d = phase_eff;
      unique case (phase_eff)
        PH_HUNT: begin
          if (rx_byte_i == start_q) begin
            sum_d   = rx_byte_i;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          len_d = rx_byte_i;
          cnt_d = 8'd0;
          sum_d = sum_q + rx_byte_i;
          if (rx_byte_i > 8'(MAX_PAYLOAD)) begin
            err_d   = err_q + 8'd1;
            push_o  = 1'b1;
            cmd_o   = '{kind: sofp_pkg::KIND_LEN_ERR, frame_len: rx_byte_i, err_cnt: err_d};
            phase_d = PH_HUNT;
          end else begin
            phase_d = (rx_byte_i == 8'd0) ? PH_SUM : PH_PAY;
          end
        end
        PH_PAY: begin
          wr_o.en = 1'b1;
          cnt_d   = cnt_q + 8'd1;
          sum_d   = sum_q + rx_byte_i;
          if (cnt_d >= len_q) phase_d = PH_SUM;
        end
        PH_SUM: begin
          push_o = 1'b1;
          if (sum_q == rx_byte_i) begin
            cmd_o.kind = (len_q == 8'd0) ? sofp_pkg::KIND_EMPTY : sofp_pkg::KIND_PAYLOAD;
          end else begin
            err_d = err_q + 8'd1;
            cmd_o = '{kind: sofp_pkg::KIND_CSUM_ERR, frame_len: len_q, err_cnt: err_d};
          end
          phase_d = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      start_q   <= sofp_pkg::START_BYTE_RST;
      timeout_q <= sofp_pkg::TIMEOUT_RST;
      len_q     <= '0;
      cnt_q     <= '0;
      sum_q     <= '0;
      err_q     <= '0;
      prev_q    <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      err_q   <= err_d;
      if (accept) prev_q <= rx_tick_i;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sofp_pkg::CFG_START_BYTE: start_q   <= cfg_data_i[7:0];
          sofp_pkg::CFG_TIMEOUT:    timeout_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/sofp_cmd_fifo.sv =====
// two-entry queue of frame verdicts between intake and drain
// depends on sofp_pkg
module sofp_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sofp_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output sofp_pkg::cmd_t cmd_o,
  output logic           full_o,
  output logic           empty_o
);

  sofp_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== hdl/sofp_back.sv =====
// result side: payload buffer, verdict drain and output register
// depends on sofp_pkg; takes verdicts from sofp_cmd_fifo
module sofp_back #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sofp_pkg::wr_t  wr_i,
  input  logic           fifo_empty_i,
  input  sofp_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           busy_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     data_o,
  output logic [7:0]     frame_len_o,
  output logic           last_o,
  output logic [7:0]     err_cnt_o
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EMIT
  } bstate_e;

  bstate_e        state_q;
  sofp_pkg::cmd_t cmd_q;
  logic [7:0]     idx_q;
  logic [7:0]     mem [MAX_PAYLOAD];
  logic [7:0]     rd_q;
  logic           can_load;
  logic           is_last;
  logic           load_out;

  assign can_load = !out_valid_o || out_ready_i;
  assign pop_o    = (state_q == B_IDLE) && !fifo_empty_i && can_load;
  assign busy_o   = (state_q != B_IDLE);
  assign is_last  = ((idx_q + 8'd1) == cmd_q.frame_len);
  assign load_out = (pop_o && (cmd_i.kind != sofp_pkg::KIND_PAYLOAD)) ||
                    ((state_q == B_EMIT) && can_load);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr[AW-1:0]] <= wr_i.data;
    rd_q <= mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_o <= 1'b0;
      cmd_q       <= '0;
      idx_q       <= '0;
      kind_o      <= '0;
      data_o      <= '0;
      frame_len_o <= '0;
      last_o      <= 1'b0;
      err_cnt_o   <= '0;
    end else begin
      out_valid_o <= load_out || (out_valid_o && !out_ready_i);
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            if (cmd_i.kind == sofp_pkg::KIND_PAYLOAD) begin
              cmd_q   <= cmd_i;
              idx_q   <= 8'd0;
              state_q <= B_READ;
            end else begin
              kind_o      <= cmd_i.kind;
              data_o      <= 8'd0;
              frame_len_o <= cmd_i.frame_len;
              last_o      <= 1'b1;
              err_cnt_o   <= cmd_i.err_cnt;
            end
          end
        end
        B_READ: state_q <= B_EMIT;
        B_EMIT: begin
          if (can_load) begin
            kind_o      <= sofp_pkg::KIND_PAYLOAD;
            data_o      <= rd_q;
            frame_len_o <= cmd_q.frame_len;
            last_o      <= is_last;
            err_cnt_o   <= cmd_q.err_cnt;
            if (is_last) begin
              state_q <= B_IDLE;
            end else begin
              idx_q   <= idx_q + 8'd1;
              state_q <= B_READ;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/sof_length_checksum_frame_parser.sv =====
// intake takes one byte per cycle when not stalled; an error or empty-frame result passes
// through the verdict queue into the output register, a good frame through the queue and
// then a buffer read and an output load for each payload byte. payload bytes of a new
// frame stall while an earlier frame drains, length and checksum bytes while the queue is full
// asynchronous active-low reset: hunting, counts cleared, start byte 0xaa, timeout 100
// ticks; the payload buffer is not cleared, every entry read was written in its frame
module sof_length_checksum_frame_parser #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // rx_byte[7:0], rx_tick[39:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // data[7:0], frame_len[15:8], error_count[23:16]
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  sofp_pkg::cmd_t push_cmd, pop_cmd;
  sofp_pkg::wr_t  wr;
  logic           push, pop, fifo_full, fifo_empty, back_busy, drain_busy;
  logic [7:0]     out_data, out_len, out_err;

  assign cfg_ready_o = 1'b1;
  assign drain_busy  = back_busy || !fifo_empty;

  sofp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .rx_byte_i    (s_axis_tdata[7:0]),
    .rx_tick_i    (s_axis_tdata[39:8]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fifo_full_i  (fifo_full),
    .drain_busy_i (drain_busy),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .wr_o         (wr)
  );

  sofp_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  sofp_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .fifo_empty_i (fifo_empty),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .busy_o       (back_busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .kind_o       (m_axis_tuser),
    .data_o       (out_data),
    .frame_len_o  (out_len),
    .last_o       (m_axis_tlast),
    .err_cnt_o    (out_err)
  );

  assign m_axis_tdata = {out_err, out_len, out_data};

`ifndef SYNTHESIS
  a_no_write_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (!back_busy && fifo_empty))
    else $error("payload buffer written while a frame drains");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full)
    else $error("verdict pushed into a full queue");

  a_single_results_are_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != sofp_pkg::KIND_PAYLOAD)) |->
      (m_axis_tlast && (out_data == 8'd0)))
    else $error("non-payload result without last or with data");
`endif

endmodule

// ===== bench/tb_sof_length_checksum_frame_parser.sv =====
// self-checking testbench for the start/length/checksum frame parser
// depends on sofp_pkg and sof_length_checksum_frame_parser; predicts results byte by byte
`timescale 1ns / 100ps

module tb_sof_length_checksum_frame_parser;

  localparam int MAX_PAYLOAD   = 64;
  localparam int PAW           = $clog2(MAX_PAYLOAD);
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SEND     = 1;
  localparam int IDLE_RECV     = 2;
  localparam int IDLE_BOTH     = 3;
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {
    HUNT, GET_LEN, GET_PAYLOAD, GET_SUM
  } parse_phase_e;

  typedef struct packed {
    sofp_pkg::kind_e kind;
    logic [7:0]      data;
    logic [7:0]      frame_len;
    logic            is_last;
    logic [7:0]      errs;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  sof_length_checksum_frame_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // parser state as predicted
  logic [7:0]   p_start = sofp_pkg::START_BYTE_RST;
  logic [31:0]  p_timeout = sofp_pkg::TIMEOUT_RST;
  parse_phase_e p_phase = HUNT;
  logic [7:0]   p_len = '0;
  logic [7:0]   p_count = '0;
  logic [7:0]   p_sum = '0;
  logic [7:0]   p_errors = '0;
  logic [31:0]  p_prev_tick = '0;
  logic [7:0]   p_payload [MAX_PAYLOAD];

  frame_result_t frame_results_q[$];
  logic [39:0]   rx_pending_q[$];

  // stimulus generator view of the settings
  logic [7:0]  cur_start = sofp_pkg::START_BYTE_RST;
  logic [31:0] cur_timeout = sofp_pkg::TIMEOUT_RST;
  logic [31:0] gen_tick;
  int          items_pushed = 0;
  bit          after_noise = 1'b0;

  int idle_mode = IDLE_NONE;
  int mismatches = 0;
  int cycle_cnt = 0;
  bit in_fire = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_result(sofp_pkg::kind_e k, logic [7:0] d, logic [7:0] l,
                                     logic lst);
    frame_result_t r;
    r.kind      = k;
    r.data      = d;
    r.frame_len = l;
    r.is_last   = lst;
    r.errs      = p_errors;
    frame_results_q.push_back(r);
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic [31:0] tick);
    logic [31:0] gap;
    int          cnt;
    gap = tick - p_prev_tick;
    if (p_phase != HUNT && gap >= p_timeout) p_phase = HUNT;
    p_prev_tick = tick;
    case (p_phase)
      HUNT: begin
        if (b == p_start) begin
          p_sum   = b;
          p_phase = GET_LEN;
        end
      end
      GET_LEN: begin
        p_len   = b;
        p_count = '0;
        p_sum   = p_sum + b;
        if (b > MAX_PAYLOAD) begin
          p_errors = p_errors + 8'd1;
          add_result(sofp_pkg::KIND_LEN_ERR, 8'd0, b, 1'b1);
          p_phase = HUNT;
        end else begin
          p_phase = (b == 8'd0) ? GET_SUM : GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        if (p_count < MAX_PAYLOAD) p_payload[p_count[PAW-1:0]] = b;
        p_count = p_count + 8'd1;
        p_sum   = p_sum + b;
        if (p_count >= p_len) p_phase = GET_SUM;
      end
      default: begin
        if (p_sum == b) begin
          if (p_len == 8'd0) begin
            add_result(sofp_pkg::KIND_EMPTY, 8'd0, 8'd0, 1'b1);
          end else begin
            cnt = (p_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(p_len);
            for (int i = 0; i < cnt; i++)
              add_result(sofp_pkg::KIND_PAYLOAD, p_payload[PAW'(i)], p_len, i + 1 == cnt);
          end
        end else begin
          p_errors = p_errors + 8'd1;
          add_result(sofp_pkg::KIND_CSUM_ERR, 8'd0, p_len, 1'b1);
        end
        p_phase = HUNT;
      end
    endcase
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    bit send_gap;
    bit recv_gap;
    send_gap = (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 67) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 34);
    recv_gap = (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 67) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 34);
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (rx_pending_q.size() != 0 && !send_gap) begin
        s_axis_tdata  <= rx_pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= !recv_gap;
  end

  // monitor: everything sampled on the rising edge
  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t want;
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_sof_length_checksum_frame_parser failed");
      $finish;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sofp_pkg::CFG_START_BYTE: p_start = cfg_data_i[7:0];
          sofp_pkg::CFG_TIMEOUT:    p_timeout = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata[7:0], s_axis_tdata[39:8]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = sofp_pkg::kind_e'(m_axis_tuser);
        got.data      = m_axis_tdata[7:0];
        got.frame_len = m_axis_tdata[15:8];
        got.is_last   = m_axis_tlast;
        got.errs      = m_axis_tdata[23:16];
        if (frame_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected result: kind %0d data %h len %0d last %b errs %0d",
                     $realtime, got.kind, got.data, got.frame_len, got.is_last, got.errs);
        end else begin
          want = frame_results_q.pop_front();
          if (got.kind !== want.kind || got.data !== want.data ||
              got.frame_len !== want.frame_len || got.is_last !== want.is_last ||
              got.errs !== want.errs) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t mismatch: expected kind %0d data %h len %0d last %b errs %0d, %s",
                       $realtime, want.kind, want.data, want.frame_len, want.is_last,
                       want.errs, $sformatf("got kind %0d data %h len %0d last %b errs %0d",
                       got.kind, got.data, got.frame_len, got.is_last, got.errs));
          end
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == sofp_pkg::CFG_START_BYTE) cur_start = val[7:0];
    else if (idx == sofp_pkg::CFG_TIMEOUT) cur_timeout = val;
  endtask

  task automatic drain_and_settle();
    @(posedge clk_i);
    while (rx_pending_q.size() != 0 || s_axis_tvalid || frame_results_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // abort selects a gap that reaches the timeout
  task automatic push_byte(logic [7:0] b, bit abort);
    logic [63:0] gap;
    if (abort) begin
      gap = 64'(cur_timeout) + 64'($urandom_range(0, 3));
      if (gap > 64'hFFFF_FFFF) gap = 64'(cur_timeout);
    end else if (cur_timeout <= 1) begin
      gap = '0;
    end else if ($urandom_range(0, 4) == 0) begin
      gap = 64'(cur_timeout - 1);
    end else begin
      gap = 64'($urandom_range(0, (cur_timeout > 1000) ? 999 : cur_timeout - 1));
    end
    gen_tick = gen_tick + gap[31:0];
    rx_pending_q.push_back({gen_tick, b});
    items_pushed++;
  endtask

  task automatic send_frame(int len, bit bad, bit abort_first);
    logic [7:0] sum;
    logic [7:0] b;
    push_byte(cur_start, abort_first);
    sum = cur_start;
    push_byte(len[7:0], 1'b0);
    sum = sum + len[7:0];
    if (len > MAX_PAYLOAD) return;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      push_byte(b, 1'b0);
      sum = sum + b;
    end
    push_byte(bad ? sum ^ 8'($urandom_range(1, 255)) : sum, 1'b0);
  endtask

  task automatic random_traffic(int n_items);
    int target;
    int sel;
    int len;
    int k;
    target = items_pushed + n_items;
    while (items_pushed < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_frame($urandom_range(0, 8), 1'b0, after_noise);
        after_noise = 1'b0;
      end else if (sel < 52) begin
        len = ($urandom_range(0, 2) == 0) ? MAX_PAYLOAD : $urandom_range(9, MAX_PAYLOAD);
        send_frame(len, 1'b0, after_noise);
        after_noise = 1'b0;
      end else if (sel < 67) begin
        send_frame($urandom_range(0, 8), 1'b1, after_noise);
        after_noise = 1'b0;
      end else if (sel < 77) begin
        send_frame($urandom_range(MAX_PAYLOAD + 1, 255), 1'b0, after_noise);
        after_noise = 1'b0;
      end else if (sel < 87) begin
        // frame cut short, the next byte comes too late
        push_byte(cur_start, after_noise);
        if ($urandom_range(0, 3) != 0) begin
          len = $urandom_range(1, 8);
          k   = $urandom_range(0, len);
          push_byte(len[7:0], 1'b0);
          for (int i = 0; i < k; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        after_noise = 1'b1;
      end else begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
        after_noise = 1'b1;
      end
    end
  endtask

  initial begin
    gen_tick = $urandom;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset settings
    idle_mode = IDLE_NONE;
    push_byte(8'hAA, 1'b0);  push_byte(8'h00, 1'b0);  push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b0);  push_byte(8'h01, 1'b0);  push_byte(8'hFF, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b0);  push_byte(8'h02, 1'b0);  push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);  push_byte(8'h00, 1'b0);
    push_byte(8'hAA, 1'b0);  push_byte(8'h41, 1'b0);
    push_byte(8'hAA, 1'b0);  push_byte(8'hFF, 1'b0);
    // late start byte drops the open frame and opens a new one
    push_byte(8'hAA, 1'b0);  push_byte(8'h03, 1'b0);  push_byte(8'h11, 1'b0);
    push_byte(8'hAA, 1'b1);  push_byte(8'h00, 1'b0);  push_byte(8'hAA, 1'b0);
    // tick count wraps inside a frame
    rx_pending_q.push_back({32'hFFFF_FFF0, 8'hAA});
    rx_pending_q.push_back({32'h0000_0010, 8'h00});
    rx_pending_q.push_back({32'h0000_0030, 8'hAA});
    gen_tick = 32'h0000_0030;
    drain_and_settle();

    // zero timeout aborts every open frame
    write_reg(sofp_pkg::CFG_TIMEOUT, 32'd0);
    push_byte(8'hAA, 1'b0);  push_byte(8'h00, 1'b0);  push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b0);  push_byte(8'h01, 1'b0);
    drain_and_settle();
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);

    write_reg(sofp_pkg::CFG_START_BYTE, 32'h00);
    write_reg(sofp_pkg::CFG_TIMEOUT, 32'd1);
    idle_mode = IDLE_NONE;
    random_traffic(28);
    drain_and_settle();

    write_reg(sofp_pkg::CFG_START_BYTE, 32'hFF);
    write_reg(sofp_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
    idle_mode = IDLE_SEND;
    random_traffic(12);
    drain_and_settle();
    random_traffic(12);
    drain_and_settle();

    write_reg(sofp_pkg::CFG_START_BYTE, $urandom_range(0, 255));
    write_reg(sofp_pkg::CFG_TIMEOUT, $urandom_range(2, 5000));
    idle_mode = IDLE_RECV;
    send_frame(MAX_PAYLOAD, 1'b0, 1'b1);
    random_traffic(26);
    drain_and_settle();

    write_reg(sofp_pkg::CFG_START_BYTE, sofp_pkg::START_BYTE_RST);
    write_reg(sofp_pkg::CFG_TIMEOUT, sofp_pkg::TIMEOUT_RST);
    idle_mode = IDLE_BOTH;
    random_traffic(26);
    drain_and_settle();

    if (mismatches == 0 && frame_results_q.size() == 0)
      $display("tb_sof_length_checksum_frame_parser passed");
    else
      $display("tb_sof_length_checksum_frame_parser failed");
    $finish;
  end

endmodule
